>>> rtl/mvt_pkg.sv
`default_nettype none

package mvt_pkg;

    localparam int DATA_W         = 32;
    localparam int COEF_W         = 32;
    localparam int NUM_ROWS       = 4;
    localparam int NUM_COLS       = 4;
    localparam int NUM_COEF_REGS  = 8;
    localparam int REG_SEL_W      = 3;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 64;

    localparam int DEF_FRAC_BITS  = 16;
    localparam int DEF_COMP_WIDTH = 32;

    // 32x32 product, pair sum, and full row sum with room for the rounding add
    localparam int PROD_W = 2 * DATA_W;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 3;

    // identity in Q16.16
    localparam logic [CFG_DATA_W-1:0] COEF_RESET [NUM_COEF_REGS] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

    typedef logic signed [DATA_W-1:0] t_word;
    typedef t_word t_word_row [NUM_COLS];

    typedef struct packed {
        logic signed [DATA_W-1:0] in_x;
        logic signed [DATA_W-1:0] in_y;
        logic signed [DATA_W-1:0] in_z;
        logic signed [DATA_W-1:0] in_w;
    } t_vec_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic signed [DATA_W-1:0] out_w;
        logic                     clipped;
    } t_vec_out;

    // one row's finished dot product
    typedef struct packed {
        logic                     vld;
        logic signed [DATA_W-1:0] value;
        logic                     sat;
    } t_lane_out;

endpackage

`default_nettype wire

>>> rtl/mvt_lane.sv
`default_nettype none

module mvt_lane #(
    parameter int FRAC_BITS  = mvt_pkg::DEF_FRAC_BITS,
    parameter int COMP_WIDTH = mvt_pkg::DEF_COMP_WIDTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_vld,
    input  mvt_pkg::t_word_row      i_coef,
    input  mvt_pkg::t_word_row      i_vec,
    output mvt_pkg::t_lane_out      o_res
);

    localparam int PROD_W = mvt_pkg::PROD_W;
    localparam int PAIR_W = mvt_pkg::PAIR_W;
    localparam int SUM_W  = mvt_pkg::SUM_W;

    // half an LSB of the result; zero when there are no fraction bits
    localparam logic signed [SUM_W-1:0] RND = (SUM_W'(1) << FRAC_BITS) >> 1;
    localparam logic signed [SUM_W-1:0] SAT_MAX = (SUM_W'(1) << (COMP_WIDTH - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

    logic                     r_vld1;
    logic                     r_vld2;
    logic signed [PROD_W-1:0] r_prod [mvt_pkg::NUM_COLS];
    logic signed [PAIR_W-1:0] r_pair [2];
    mvt_pkg::t_lane_out       r_res;

    logic signed [SUM_W-1:0]  n_sum;
    logic signed [SUM_W-1:0]  n_shift;
    logic signed [SUM_W-1:0]  n_clamp;
    logic                     n_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    // stage 1: four products
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < mvt_pkg::NUM_COLS; k++) begin
            r_prod[k] <= PROD_W'(i_coef[k]) * PROD_W'(i_vec[k]);
        end
    end

    // stage 2: pair sums
    always_ff @(posedge i_clk) begin
        r_pair[0] <= PAIR_W'(r_prod[0]) + PAIR_W'(r_prod[1]);
        r_pair[1] <= PAIR_W'(r_prod[2]) + PAIR_W'(r_prod[3]);
    end

    // stage 3: final add with round-half-up, scale back, clamp
    always_comb begin
        n_sum   = SUM_W'(r_pair[0]) + SUM_W'(r_pair[1]) + RND;
        n_shift = n_sum >>> FRAC_BITS;
        n_sat   = 1'b0;
        n_clamp = n_shift;
        if (n_shift > SAT_MAX) begin
            n_clamp = SAT_MAX;
            n_sat   = 1'b1;
        end else if (n_shift < SAT_MIN) begin
            n_clamp = SAT_MIN;
            n_sat   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.vld <= 1'b0;
        end else begin
            r_res.vld <= r_vld2;
        end
        r_res.value <= n_clamp[mvt_pkg::DATA_W-1:0];
        r_res.sat   <= n_sat;
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

>>> rtl/mvt_merge.sv
`default_nettype none

module mvt_merge (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  mvt_pkg::t_lane_out  i_lane [mvt_pkg::NUM_ROWS],
    output logic                o_valid,
    output mvt_pkg::t_vec_out   o_out
);

    logic              r_valid;
    mvt_pkg::t_vec_out r_out;
    logic              n_any_sat;
    logic              n_all_vld;

    // lanes run in lockstep, so all valids agree
    always_comb begin
        n_any_sat = 1'b0;
        n_all_vld = 1'b1;
        for (int r = 0; r < mvt_pkg::NUM_ROWS; r++) begin
            n_any_sat = n_any_sat | i_lane[r].sat;
            n_all_vld = n_all_vld & i_lane[r].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_all_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.out_x   <= i_lane[0].value;
        r_out.out_y   <= i_lane[1].value;
        r_out.out_z   <= i_lane[2].value;
        r_out.out_w   <= i_lane[3].value;
        r_out.clipped <= n_any_sat;
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

`default_nettype wire

>>> rtl/mat4_vector_transform.sv
`default_nettype none

// 4x4 Q16.16 matrix times 4-component vector. Takes one item per clock with
// no gaps: busy is high only during reset and the cycle after it. Each row is
// its own lane of four 32x32 multipliers followed by a two-level adder, round
// and clamp; a merge stage joins the four rows and ORs the clamp flags into
// clipped. Each item passes five register stages (input register, multiply,
// pair add, final add/round/clamp, output register); its result is then on
// o_out with o_valid high for one cycle. The receiver cannot stall, so results
// must be taken when o_valid is high. Coefficient registers reset to identity;
// write them only while no item is in flight. Writes to an index past the last
// register are dropped.
module mat4_vector_transform #(
    parameter int FRAC_BITS  = mvt_pkg::DEF_FRAC_BITS,
    parameter int COMP_WIDTH = mvt_pkg::DEF_COMP_WIDTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  mvt_pkg::t_vec_in                        i_in,
    output logic                                    o_valid,
    output mvt_pkg::t_vec_out                       o_out,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [mvt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [mvt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int DATA_W = mvt_pkg::DATA_W;
    localparam int COEF_W = mvt_pkg::COEF_W;

    logic                                r_rdy;
    logic [mvt_pkg::CFG_DATA_W-1:0]      r_coef [mvt_pkg::NUM_COEF_REGS];
    logic                                r_in_vld;
    mvt_pkg::t_word_row                  r_vec;
    mvt_pkg::t_word_row                  n_vec;
    mvt_pkg::t_word_row                  w_coef [mvt_pkg::NUM_ROWS];
    mvt_pkg::t_lane_out                  w_lane [mvt_pkg::NUM_ROWS];
    logic                                w_accept;

    assign busy        = !r_rdy;
    assign o_cfg_ready = r_rdy;
    assign w_accept    = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy    <= 1'b0;
            r_in_vld <= 1'b0;
        end else begin
            r_rdy    <= 1'b1;
            r_in_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mvt_pkg::NUM_COEF_REGS; i++) begin
                r_coef[i] <= mvt_pkg::COEF_RESET[i];
            end
        end else if (i_cfg_valid && o_cfg_ready
                     && i_cfg_index < mvt_pkg::CFG_IDX_W'(mvt_pkg::NUM_COEF_REGS)) begin
            r_coef[i_cfg_index[mvt_pkg::REG_SEL_W-1:0]] <= i_cfg_data;
        end
    end

    // components are the low COMP_WIDTH bits, sign-extended
    always_comb begin
        n_vec[0] = DATA_W'(signed'(i_in.in_x[COMP_WIDTH-1:0]));
        n_vec[1] = DATA_W'(signed'(i_in.in_y[COMP_WIDTH-1:0]));
        n_vec[2] = DATA_W'(signed'(i_in.in_z[COMP_WIDTH-1:0]));
        n_vec[3] = DATA_W'(signed'(i_in.in_w[COMP_WIDTH-1:0]));
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_vec <= n_vec;
        end
    end

    for (genvar r = 0; r < mvt_pkg::NUM_ROWS; r++) begin : g_row
        for (genvar k = 0; k < mvt_pkg::NUM_COLS; k++) begin : g_col
            assign w_coef[r][k] = r_coef[r * 2 + k / 2][(k % 2) * COEF_W +: COEF_W];
        end

        mvt_lane #(
            .FRAC_BITS  (FRAC_BITS),
            .COMP_WIDTH (COMP_WIDTH)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (r_in_vld),
            .i_coef  (w_coef[r]),
            .i_vec   (r_vec),
            .o_res   (w_lane[r])
        );
    end

    mvt_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_lane  (w_lane),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    localparam logic [DATA_W-1:0] OUT_MAX = DATA_W'((64'(1) << (COMP_WIDTH - 1)) - 64'(1));
    localparam logic [DATA_W-1:0] OUT_MIN = ~OUT_MAX;

    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_valid)
        else $error("accepted item produced no result");

    a_latency_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 5))
        else $error("result without a matching item");

    a_clip_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.clipped) |->
            (o_out.out_x == OUT_MAX || o_out.out_x == OUT_MIN ||
             o_out.out_y == OUT_MAX || o_out.out_y == OUT_MIN ||
             o_out.out_z == OUT_MAX || o_out.out_z == OUT_MIN ||
             o_out.out_w == OUT_MAX || o_out.out_w == OUT_MIN))
        else $error("clipped set but no component at a bound");
`endif

endmodule

`default_nettype wire

>>> verif/mat4_vector_transform_tb.sv
`default_nettype none

module mat4_vector_transform_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mvt_pkg::*;

    localparam int FRAC          = DEF_FRAC_BITS;
    localparam int SETTLE_CYCLES = 10;
    localparam int RAND_PHASES   = 6;
    localparam int RAND_ITEMS    = 105;
    localparam int CYCLE_LIMIT   = 100_000;

    localparam t_word WORD_MAX = 32'sh7FFF_FFFF;
    localparam t_word WORD_MIN = 32'sh8000_0000;
    localparam t_word ONE_Q    = 32'sh0001_0000;

    localparam logic signed [67:0] ROW_MAX = (68'sd1 <<< (DEF_COMP_WIDTH - 1)) - 68'sd1;
    localparam logic signed [67:0] ROW_MIN = -(68'sd1 <<< (DEF_COMP_WIDTH - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_R0_C01, REG_R0_C23, REG_R1_C01, REG_R1_C23,
        REG_R2_C01, REG_R2_C23, REG_R3_C01, REG_R3_C23
    } coef_reg_e;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    t_vec_in               i_in        = '0;
    logic                  o_valid;
    t_vec_out              o_out;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    mat4_vector_transform u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow copy of the coefficient registers
    logic [CFG_DATA_W-1:0] coef_regs [NUM_COEF_REGS];

    t_vec_in  pending_vecs  [$];
    t_vec_out expected_vecs [$];
    int       mismatches = 0;
    int       cycles     = 0;
    logic     took_vec   = 1'b0;
    int       burst_left = 0;
    int       gap_left   = 0;

    function automatic t_vec_out transform_vector(t_vec_in v);
        t_word              comp [NUM_COLS];
        t_word              res  [NUM_ROWS];
        logic [CFG_DATA_W-1:0] reg_val;
        logic signed [67:0] cw;
        logic signed [67:0] vw;
        logic signed [67:0] sum;
        logic signed [67:0] rounded;
        logic               clip;
        t_vec_out           r;
        comp[0] = v.in_x;
        comp[1] = v.in_y;
        comp[2] = v.in_z;
        comp[3] = v.in_w;
        clip = 1'b0;
        for (int row = 0; row < NUM_ROWS; row++) begin
            sum = '0;
            for (int col = 0; col < NUM_COLS; col++) begin
                reg_val = coef_regs[row * 2 + col / 2];
                cw = t_word'(reg_val[(col % 2) * COEF_W +: COEF_W]);
                vw = comp[col];
                sum = sum + cw * vw;
            end
            // round half toward plus infinity, then clamp
            rounded = (sum + (68'sd1 <<< (FRAC - 1))) >>> FRAC;
            if (rounded > ROW_MAX) begin
                res[row] = WORD_MAX;
                clip = 1'b1;
            end else if (rounded < ROW_MIN) begin
                res[row] = WORD_MIN;
                clip = 1'b1;
            end else begin
                res[row] = rounded[DATA_W-1:0];
            end
        end
        r.out_x   = res[0];
        r.out_y   = res[1];
        r.out_z   = res[2];
        r.out_w   = res[3];
        r.clipped = clip;
        return r;
    endfunction

    function automatic t_word corner_word();
        case ($urandom_range(0, 4))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    function automatic t_word rand_component();
        int unsigned k;
        k = $urandom_range(0, 19);
        if (k < 6)
            return $urandom();
        else if (k < 14)
            return int'($urandom_range(0, 33554431)) - 16777216;
        else if (k < 17)
            return int'($urandom_range(0, 262143)) - 131072;
        else
            return corner_word();
    endfunction

    function automatic t_word rand_coef();
        int unsigned k;
        k = $urandom_range(0, 7);
        if (k < 2)
            return $urandom();
        else if (k < 6)
            return int'($urandom_range(0, 524287)) - 262144;   // within +/-4.0
        else if (k == 6)
            return $urandom_range(0, 1) ? ONE_Q : -ONE_Q;
        else
            return corner_word();
    endfunction

    task automatic queue_vec(t_word x, t_word y, t_word z, t_word w);
        t_vec_in v;
        v.in_x = x;
        v.in_y = y;
        v.in_z = z;
        v.in_w = w;
        pending_vecs.push_back(v);
    endtask

    // called at a falling edge; returns at a falling edge with valid still high
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < NUM_COEF_REGS)
            coef_regs[idx] = data;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_vecs.size() != 0 || start || expected_vecs.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // item driver: bursts of random length, random gaps between them
    always @(negedge i_clk) begin : drive_items
        logic    nxt_start;
        t_vec_in nxt_vec;
        nxt_start = start;
        nxt_vec   = i_in;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
        end else if (!start || took_vec) begin
            nxt_start = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_vecs.size() != 0) begin
                nxt_start = 1'b1;
                nxt_vec   = pending_vecs.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end
        end
        start <= nxt_start;
        i_in  <= nxt_vec;
    end

    always @(posedge i_clk) begin : check_results
        t_vec_out want;
        took_vec <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy)
            expected_vecs.push_back(transform_vector(i_in));
        if (i_rst_n && o_valid) begin
            if (expected_vecs.size() == 0) begin
                $error("result with no item outstanding");
                mismatches++;
            end else begin
                want = expected_vecs.pop_front();
                if (o_out.out_x !== want.out_x) begin
                    $error("out_x: expected %0d, got %0d", want.out_x, o_out.out_x);
                    mismatches++;
                end
                if (o_out.out_y !== want.out_y) begin
                    $error("out_y: expected %0d, got %0d", want.out_y, o_out.out_y);
                    mismatches++;
                end
                if (o_out.out_z !== want.out_z) begin
                    $error("out_z: expected %0d, got %0d", want.out_z, o_out.out_z);
                    mismatches++;
                end
                if (o_out.out_w !== want.out_w) begin
                    $error("out_w: expected %0d, got %0d", want.out_w, o_out.out_w);
                    mismatches++;
                end
                if (o_out.clipped !== want.clipped) begin
                    $error("clipped: expected %0b, got %0b", want.clipped, o_out.clipped);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NUM_COEF_REGS; i++)
            coef_regs[i] = COEF_RESET[i];
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // identity after reset: output equals input
        @(posedge i_clk);
        queue_vec(0, 0, 0, 0);
        queue_vec(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
        queue_vec(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
        queue_vec(-1, -1, -1, -1);
        queue_vec(1, 2, 3, 4);
        queue_vec(WORD_MAX, WORD_MIN, -1, 1);
        wait_drained();

        // one-LSB coefficients expose round-half-up; row 3 drives both clamps
        cfg_write(REG_R0_C01, {32'h0, 32'h1});
        cfg_write(REG_R0_C23, '0);
        cfg_write(REG_R1_C01, {32'h0, 32'hFFFF_FFFF});
        cfg_write(REG_R1_C23, '0);
        cfg_write(REG_R2_C01, {32'h1, 32'h0});
        cfg_write(REG_R2_C23, '0);
        cfg_write(REG_R3_C01, '0);
        cfg_write(REG_R3_C23, {WORD_MAX, WORD_MIN});
        // writes past the last register must be dropped
        cfg_write(CFG_IDX_W'(NUM_COEF_REGS), '1);
        cfg_write(CFG_IDX_W'((1 << CFG_IDX_W) - 1), '1);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        queue_vec(32'sh8000, 0, 0, 0);
        queue_vec(-32'sh8000, 0, 0, 0);
        queue_vec(32'sh7FFF, 0, 0, 0);
        queue_vec(32'sh8001, 0, 0, 0);
        queue_vec(0, 32'sh18000, 0, 0);
        queue_vec(0, -32'sh18000, 0, 0);
        queue_vec(0, 0, WORD_MIN, 0);
        queue_vec(0, 0, 0, WORD_MIN);
        queue_vec(0, 0, WORD_MAX, WORD_MAX);
        wait_drained();

        // every coefficient at the negative bound: sum reaches 2^64
        for (int i = 0; i < NUM_COEF_REGS; i++)
            cfg_write(CFG_IDX_W'(i), {WORD_MIN, WORD_MIN});
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        queue_vec(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
        queue_vec(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
        queue_vec(0, 0, 0, 0);
        wait_drained();

        for (int i = 0; i < NUM_COEF_REGS; i++)
            cfg_write(CFG_IDX_W'(i), {WORD_MAX, WORD_MAX});
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        queue_vec(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
        queue_vec(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
        queue_vec(1, -1, 1, -1);
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++) begin
            for (int i = 0; i < NUM_COEF_REGS; i++)
                cfg_write(CFG_IDX_W'(i), {rand_coef(), rand_coef()});
            if ($urandom_range(0, 1))
                cfg_write(CFG_IDX_W'($urandom_range(NUM_COEF_REGS, (1 << CFG_IDX_W) - 1)),
                          {$urandom(), $urandom()});
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
            for (int n = 0; n < RAND_ITEMS; n++)
                queue_vec(rand_component(), rand_component(), rand_component(),
                          rand_component());
            wait_drained();
        end

        if (mismatches == 0 && expected_vecs.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
